// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when ante holds, cons must hold at the same edge
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// when ante holds, cons must hold at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/hpts_pkg.sv =====
// Types and constants of the heading PID turn controller.
`default_nettype none

package hpts_pkg;

  // field widths
  localparam int unsigned AngleW   = 17;
  localparam int unsigned HeadingW = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned TolW     = 12;
  localparam int unsigned SettleW  = 8;
  localparam int unsigned TickW    = 16;
  localparam int unsigned SumW     = 32;
  localparam int unsigned SpeedW   = 17;
  localparam int unsigned DerrW    = AngleW + 1;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    RegTarget   = 3'd0,
    RegGainP    = 3'd1,
    RegGainI    = 3'd2,
    RegGainD    = 3'd3,
    RegTol      = 3'd4,
    RegSettle   = 3'd5,
    RegTimeout  = 3'd6,
    RegNone     = 3'd7
  } cfg_reg_e;

  // product and accumulator widths
  localparam int unsigned PrdPW  = AngleW + GainW + 1;
  localparam int unsigned PrdIW  = SumW + GainW + 1;
  localparam int unsigned PrdDW  = DerrW + GainW + 1;
  localparam int unsigned AccW   = PrdIW + 1;
  localparam int unsigned FracW  = 8;
  localparam int unsigned ShW    = AccW - FracW;
  localparam int          RoundBias  = 128;
  localparam int          SpeedLimit = 60000;

  // completion state, one-hot
  typedef enum logic [2:0] {
    FinRun      = 3'b001,
    FinSettled  = 3'b010,
    FinTimedOut = 3'b100
  } fin_state_e;

  typedef struct packed {
    logic signed [AngleW-1:0] target_angle;
    logic [GainW-1:0]         gain_p;
    logic [GainW-1:0]         gain_i;
    logic [GainW-1:0]         gain_d;
    logic [TolW-1:0]          settle_tolerance;
    logic [SettleW-1:0]       settle_count;
    logic [TickW-1:0]         timeout_ticks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    target_angle:     17'sd0,
    gain_p:           16'd154,
    gain_i:           16'd0,
    gain_d:           16'd512,
    settle_tolerance: 12'd50,
    settle_count:     8'd5,
    timeout_ticks:    16'd300
  };

  // classified tick handed from front to back
  typedef struct packed {
    logic                     active;
    logic                     settled;
    logic                     timed_out;
    logic signed [AngleW-1:0] err;
    logic signed [SumW-1:0]   sum;
    logic signed [DerrW-1:0]  derr;
  } job_t;

endpackage

`default_nettype wire

// ===== src/hpts_if.sv =====
// Channel interfaces: heading input, speed output, configuration writes.
`default_nettype none

interface hpts_in_if;
  logic                             valid;
  logic                             ready;
  logic [hpts_pkg::HeadingW-1:0]    heading_sample;
  logic                             restart;

  modport source (output valid, heading_sample, restart, input ready);
  modport sink   (input valid, heading_sample, restart, output ready);
endinterface

interface hpts_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [hpts_pkg::SpeedW-1:0] left_speed;
  logic signed [hpts_pkg::SpeedW-1:0] right_speed;
  logic                             settled;
  logic                             timed_out;

  modport source (output valid, left_speed, right_speed, settled, timed_out, input ready);
  modport sink   (input valid, left_speed, right_speed, settled, timed_out, output ready);
endinterface

interface hpts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hpts_pkg::CfgIdxW-1:0]     index;
  logic [hpts_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/hpts_front.sv =====
// Front end: takes heading words, updates loop state, classifies each tick.
`default_nettype none

module hpts_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  hpts_in_if.sink             in_i,
  input  wire hpts_pkg::cfg_t cfg_i,
  input  wire logic           full_i,
  output logic                push_o,
  output hpts_pkg::job_t      push_data_o
);

  localparam int unsigned AW = hpts_pkg::AngleW;
  localparam int unsigned SW = hpts_pkg::SumW;
  localparam int unsigned DW = hpts_pkg::DerrW;

  hpts_pkg::fin_state_e             fin_q, fin_d, fin_cur;
  logic signed [SW-1:0]             sum_q, sum_d, sum_cur;
  logic signed [AW-1:0]             last_q, last_d, last_cur;
  logic [hpts_pkg::SettleW-1:0]     run_q, run_d, run_cur, run_nxt;
  logic [hpts_pkg::TickW-1:0]       tick_q, tick_d, tick_cur;

  logic signed [DW-1:0]             raw;
  logic [DW-1:0]                    mag;
  logic signed [AW-1:0]             err;
  logic signed [SW:0]               sum_wide;
  logic signed [SW-1:0]             sum_sat;
  logic                             hit;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // restart clears the run before this tick is evaluated
  always_comb begin
    fin_cur  = in_i.restart ? hpts_pkg::FinRun : fin_q;
    sum_cur  = in_i.restart ? '0 : sum_q;
    last_cur = in_i.restart ? '0 : last_q;
    run_cur  = in_i.restart ? '0 : run_q;
    tick_cur = in_i.restart ? '0 : tick_q;
  end

  // error, saturated integral, on-target test and next run count
  always_comb begin
    raw = {cfg_i.target_angle[AW-1], cfg_i.target_angle}
        - $signed({2'b00, in_i.heading_sample});
    // only negative overflow is possible
    if (raw[DW-1] && !raw[DW-2]) begin
      err = {1'b1, {(AW-1){1'b0}}};
    end else begin
      err = raw[AW-1:0];
    end
    sum_wide = {sum_cur[SW-1], sum_cur} + (SW+1)'(err);
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
    mag = raw[DW-1] ? DW'(-raw) : DW'(raw);
    hit = mag < DW'(cfg_i.settle_tolerance);
    if (!hit) begin
      run_nxt = '0;
    end else if (&run_cur) begin
      run_nxt = run_cur;
    end else begin
      run_nxt = run_cur + 1'b1;
    end
  end

  // tick sequencing
  always_comb begin
    fin_d  = fin_cur;
    sum_d  = sum_cur;
    last_d = last_cur;
    run_d  = run_cur;
    tick_d = tick_cur;
    unique case (fin_cur)
      hpts_pkg::FinRun: begin
        if (tick_cur >= cfg_i.timeout_ticks) begin
          fin_d = hpts_pkg::FinTimedOut;
        end else begin
          sum_d  = sum_sat;
          last_d = err;
          tick_d = tick_cur + 1'b1;
          run_d  = run_nxt;
          if (run_nxt >= cfg_i.settle_count) begin
            fin_d = hpts_pkg::FinSettled;
          end
        end
      end
      default: ;
    endcase

    push_data_o.active    = (fin_d == hpts_pkg::FinRun);
    push_data_o.settled   = (fin_d == hpts_pkg::FinSettled);
    push_data_o.timed_out = (fin_d == hpts_pkg::FinTimedOut);
    push_data_o.err       = err;
    push_data_o.sum       = sum_sat;
    push_data_o.derr      = DW'(err) - DW'(last_cur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q  <= hpts_pkg::FinRun;
      sum_q  <= '0;
      last_q <= '0;
      run_q  <= '0;
      tick_q <= '0;
    end else if (push_o) begin
      fin_q  <= fin_d;
      sum_q  <= sum_d;
      last_q <= last_d;
      run_q  <= run_d;
      tick_q <= tick_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/hpts_queue.sv =====
// Small FIFO between the front and back ends.
`default_nettype none

module hpts_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hpts_pkg::job_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output hpts_pkg::job_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hpts_pkg::job_t    slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  // payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/hpts_back.sv =====
// Back end: gain products, then rounding, clamp and output register.
`default_nettype none

module hpts_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hpts_pkg::cfg_t cfg_i,
  input  wire logic           empty_i,
  input  wire hpts_pkg::job_t pop_data_i,
  output logic                pop_o,
  hpts_out_if.source          out_o
);

  localparam int unsigned PW  = hpts_pkg::PrdPW;
  localparam int unsigned IW  = hpts_pkg::PrdIW;
  localparam int unsigned DPW = hpts_pkg::PrdDW;
  localparam int unsigned AW  = hpts_pkg::AccW;
  localparam int unsigned SHW = hpts_pkg::ShW;
  localparam int unsigned OW  = hpts_pkg::SpeedW;
  localparam logic signed [SHW-1:0] SpeedHi = SHW'(hpts_pkg::SpeedLimit);
  localparam logic signed [SHW-1:0] SpeedLo = SHW'(-hpts_pkg::SpeedLimit);

  logic                 s1_valid_q, out_valid_q, adv, load_s1;
  logic                 s1_active_q, s1_settled_q, s1_timed_q;
  logic signed [PW-1:0]  prd_p_q;
  logic signed [IW-1:0]  prd_i_q;
  logic signed [DPW-1:0] prd_d_q;

  logic signed [AW-1:0]  acc;
  logic signed [SHW-1:0] speed_wide;
  logic signed [OW-1:0]  speed;

  logic signed [OW-1:0]  left_q, right_q;
  logic                  settled_q, timed_q;

  assign adv     = !out_valid_q || out_o.ready;
  assign load_s1 = !s1_valid_q || adv;
  assign pop_o   = !empty_i && load_s1;

  // stage 1: three gain products
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prd_p_q      <= pop_data_i.err  * $signed({1'b0, cfg_i.gain_p});
      prd_i_q      <= pop_data_i.sum  * $signed({1'b0, cfg_i.gain_i});
      prd_d_q      <= pop_data_i.derr * $signed({1'b0, cfg_i.gain_d});
      s1_active_q  <= pop_data_i.active;
      s1_settled_q <= pop_data_i.settled;
      s1_timed_q   <= pop_data_i.timed_out;
    end
  end

  // stage 2: sum, round to nearest, clamp; zero speed once the run has finished
  always_comb begin
    acc = AW'(prd_p_q) + AW'(prd_i_q) + AW'(prd_d_q) + AW'(hpts_pkg::RoundBias);
    speed_wide = SHW'(acc >>> hpts_pkg::FracW);
    if (!s1_active_q) begin
      speed = '0;
    end else if (speed_wide > SpeedHi) begin
      speed = OW'(SpeedHi);
    end else if (speed_wide < SpeedLo) begin
      speed = OW'(SpeedLo);
    end else begin
      speed = OW'(speed_wide);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      left_q    <= speed;
      right_q   <= -speed;
      settled_q <= s1_settled_q;
      timed_q   <= s1_timed_q;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_s1) begin
        s1_valid_q <= !empty_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_speed  = left_q;
  assign out_o.right_speed = right_q;
  assign out_o.settled     = settled_q;
  assign out_o.timed_out   = timed_q;

endmodule

`default_nettype wire

// ===== src/heading_pid_turn_with_settle.sv =====
// Heading PID turn controller with settle and timeout detection.
//
// Channels: in_i carries one heading word per control tick (heading_sample,
// restart); out_o returns one word per tick (left_speed, right_speed =
// -left_speed, settled, timed_out); cfg_i writes the seven control registers
// by index (target, gain P/I/D, tolerance, settle count, timeout) and is
// always ready. The user must write registers only while no tick is in
// flight; the block does not enforce it. Throughput: one tick per clock
// while out_o does not stall. The loop state (integral, previous error, run
// and tick counters, completion state) is updated in the front end as each
// word is accepted; the gain products and rounding run afterwards in a
// two-stage back end behind a small FIFO. Reset clears the loop state,
// loads the register defaults and empties the pipeline. When out_o stalls,
// the back end holds its result; the FIFO keeps taking words until it is
// full, then in_i.ready drops.
`default_nettype none

module heading_pid_turn_with_settle #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hpts_in_if.sink   in_i,
  hpts_out_if.source out_o,
  hpts_cfg_if.sink  cfg_i
);

  hpts_pkg::cfg_t cfg_q;
  hpts_pkg::job_t push_data, pop_data;
  logic           push, full, pop, empty;

  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hpts_pkg::CfgReset;
    end else if (cfg_i.valid) begin
      unique case (hpts_pkg::cfg_reg_e'(cfg_i.index))
        hpts_pkg::RegTarget:  cfg_q.target_angle     <= cfg_i.data[16:0];
        hpts_pkg::RegGainP:   cfg_q.gain_p           <= cfg_i.data[15:0];
        hpts_pkg::RegGainI:   cfg_q.gain_i           <= cfg_i.data[15:0];
        hpts_pkg::RegGainD:   cfg_q.gain_d           <= cfg_i.data[15:0];
        hpts_pkg::RegTol:     cfg_q.settle_tolerance <= cfg_i.data[11:0];
        hpts_pkg::RegSettle:  cfg_q.settle_count     <= cfg_i.data[7:0];
        hpts_pkg::RegTimeout: cfg_q.timeout_ticks    <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  hpts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hpts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  hpts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ===== src/hpts_checker.sv =====
// Port-level checks of the turn controller output, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module hpts_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic signed [hpts_pkg::SpeedW-1:0] left_speed_i,
  input wire logic signed [hpts_pkg::SpeedW-1:0] right_speed_i,
  input wire logic                              settled_i,
  input wire logic                              timed_out_i
);

  // no word reports both outcomes at once
  `ASSERT_IMPLIES(a_one_outcome, clk_i, rst_ni, out_valid_i, !(settled_i && timed_out_i), "both flags set")

  // finished ticks brake both motors
  `ASSERT_IMPLIES(a_brake_when_done, clk_i, rst_ni, out_valid_i && (settled_i || timed_out_i), (left_speed_i == '0) && (right_speed_i == '0), "nonzero speed after finish")

  // right motor mirrors left, speed within limit
  `ASSERT_IMPLIES(a_mirror_clamp, clk_i, rst_ni, out_valid_i, (right_speed_i == -left_speed_i) && (left_speed_i <= 17'sd60000) && (left_speed_i >= -17'sd60000), "speed pair out of range")

  // stalled result is held
  `ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(left_speed_i) && $stable(settled_i) && $stable(timed_out_i), "stalled word changed")

endmodule

bind heading_pid_turn_with_settle hpts_checker u_hpts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .left_speed_i  (out_o.left_speed),
  .right_speed_i (out_o.right_speed),
  .settled_i     (out_o.settled),
  .timed_out_i   (out_o.timed_out)
);

`default_nettype wire

// ===== test/tb_heading_pid_turn_with_settle.sv =====
// Self-checking testbench for the heading PID turn controller with settle and timeout.
module tb_heading_pid_turn_with_settle;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SpeedW     = hpts_pkg::SpeedW;
  localparam int unsigned SumW       = hpts_pkg::SumW;
  localparam int unsigned AngleW     = hpts_pkg::AngleW;
  localparam int unsigned SettleW    = hpts_pkg::SettleW;
  localparam int unsigned TickW      = hpts_pkg::TickW;
  localparam int unsigned HeadingW   = hpts_pkg::HeadingW;
  localparam int unsigned CfgDataW   = hpts_pkg::CfgDataW;
  localparam int unsigned GainW      = hpts_pkg::GainW;
  localparam int unsigned TolW       = hpts_pkg::TolW;
  localparam int unsigned FracW      = hpts_pkg::FracW;
  localparam int          RoundBias  = hpts_pkg::RoundBias;
  localparam int          SpeedLimit = hpts_pkg::SpeedLimit;

  localparam int unsigned StallLimit  = 1000;  // cycles with no word moving
  localparam int unsigned HoldCycles  = 80;    // long receiver hold-off
  localparam int unsigned DrainCycles = 4;     // idle margin after the last word returns
  localparam int unsigned RandomTicks = 60;
  localparam int unsigned RampTicks   = 20;    // full-error ticks in the integral ramp
  localparam int          ErrMax      = 65535;
  localparam int          ErrMin      = -65536;
  localparam int          HeadingMax  = 35999;

  // one output word as the block should show it
  typedef struct packed {
    logic signed [SpeedW-1:0] left_speed;
    logic signed [SpeedW-1:0] right_speed;
    logic                     settled;
    logic                     timed_out;
  } drive_word_t;

  logic clk;
  logic rst_n;

  hpts_in_if  in_ch ();
  hpts_out_if out_ch ();
  hpts_cfg_if cfg_ch ();

  heading_pid_turn_with_settle u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // shadow of the controller: registers and loop state
  hpts_pkg::cfg_t           ctl;
  logic signed [SumW-1:0]   integ;
  logic signed [AngleW-1:0] prev_err;
  logic [SettleW-1:0]       on_run;
  logic [TickW-1:0]         ticks;
  hpts_pkg::fin_state_e     fin;

  drive_word_t drive_q[$];

  int  mismatches;
  int  words_checked;
  int  ticks_sent;
  int  cfg_writes;
  int  n_settled;
  int  n_timeouts;
  int  hold_req;
  int  hold_seen;
  bit  steady;
  int unsigned quiet;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // start of a new turn: integral, history and counters cleared
  function automatic void clear_loop();
    integ    = '0;
    prev_err = '0;
    on_run   = '0;
    ticks    = '0;
    fin      = hpts_pkg::FinRun;
  endfunction

  // one control tick of the controller, updating the shadow state
  function automatic drive_word_t steer_tick(logic [HeadingW-1:0] hdg, bit restart);
    longint      raw;
    longint      err;
    longint      sum;
    longint      acc;
    longint      spd;
    longint      mag;
    drive_word_t w;
    if (restart) clear_loop();
    spd = 0;
    if (fin == hpts_pkg::FinRun) begin
      if (ticks >= ctl.timeout_ticks) begin
        fin = hpts_pkg::FinTimedOut;
        n_timeouts++;
      end else begin
        raw = longint'($signed(ctl.target_angle)) - longint'(hdg);
        err = raw;
        if (err > ErrMax) err = ErrMax;
        if (err < ErrMin) err = ErrMin;
        sum = longint'(integ) + err;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        integ = SumW'(sum);
        acc = err * longint'(ctl.gain_p) + sum * longint'(ctl.gain_i)
            + (err - longint'(prev_err)) * longint'(ctl.gain_d);
        // round to nearest, ties upward, then clamp to motor range
        spd = (acc + RoundBias) >>> FracW;
        if (spd > SpeedLimit) spd = SpeedLimit;
        if (spd < -SpeedLimit) spd = -SpeedLimit;
        prev_err = AngleW'(err);
        ticks    = ticks + 1'b1;
        // tolerance uses the unclamped error
        mag = (raw < 0) ? -raw : raw;
        if (mag < longint'(ctl.settle_tolerance)) begin
          if (on_run != '1) on_run = on_run + 1'b1;
        end else begin
          on_run = '0;
        end
        if (on_run >= ctl.settle_count) begin
          fin = hpts_pkg::FinSettled;
          n_settled++;
        end
      end
    end
    if (fin != hpts_pkg::FinRun) spd = 0;
    w.left_speed  = SpeedW'(spd);
    w.right_speed = SpeedW'(-spd);
    w.settled     = (fin == hpts_pkg::FinSettled);
    w.timed_out   = (fin == hpts_pkg::FinTimedOut);
    return w;
  endfunction

  // send one heading word, with random gaps, and queue its expected drive word
  task automatic send_word(logic [HeadingW-1:0] hdg, bit restart);
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.heading_sample <= hdg;
    in_ch.restart        <= restart;
    do @(posedge clk); while (!in_ch.ready);
    drive_q.push_back(steer_tick(hdg, restart));
    ticks_sent++;
  endtask

  // stop sending and let every queued word come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one register write; the shadow copy follows at the accepting edge
  task automatic write_reg(hpts_pkg::cfg_reg_e idx, int value);
    logic [CfgDataW-1:0] data;
    data = CfgDataW'(value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      hpts_pkg::RegTarget:  ctl.target_angle     = data[AngleW-1:0];
      hpts_pkg::RegGainP:   ctl.gain_p           = data[GainW-1:0];
      hpts_pkg::RegGainI:   ctl.gain_i           = data[GainW-1:0];
      hpts_pkg::RegGainD:   ctl.gain_d           = data[GainW-1:0];
      hpts_pkg::RegTol:     ctl.settle_tolerance = data[TolW-1:0];
      hpts_pkg::RegSettle:  ctl.settle_count     = data[SettleW-1:0];
      hpts_pkg::RegTimeout: ctl.timeout_ticks    = data[TickW-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // program all seven registers once the block has gone quiet
  task automatic load_settings(int tgt, int gp, int gi, int gd, int tol, int cnt, int tmo);
    wait_idle();
    write_reg(hpts_pkg::RegTarget, tgt);
    write_reg(hpts_pkg::RegGainP, gp);
    write_reg(hpts_pkg::RegGainI, gi);
    write_reg(hpts_pkg::RegGainD, gd);
    write_reg(hpts_pkg::RegTol, tol);
    write_reg(hpts_pkg::RegSettle, cnt);
    write_reg(hpts_pkg::RegTimeout, tmo);
  endtask

  function automatic logic [HeadingW-1:0] clip_heading(int h);
    if (h < 0) return '0;
    if (h > HeadingMax) return HeadingW'(HeadingMax);
    return HeadingW'(h);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 17);
    end
  end

  // compare each returned drive word with the oldest expectation
  always @(posedge clk) begin
    drive_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_q.size() == 0) begin
        $error("drive word returned with no heading tick pending");
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        words_checked++;
        if (out_ch.left_speed !== want.left_speed) begin
          $error("left_speed: expected %0d, got %0d", want.left_speed, out_ch.left_speed);
          mismatches++;
        end
        if (out_ch.right_speed !== want.right_speed) begin
          $error("right_speed: expected %0d, got %0d", want.right_speed, out_ch.right_speed);
          mismatches++;
        end
        if (out_ch.settled !== want.settled) begin
          $error("settled: expected %0b, got %0b", want.settled, out_ch.settled);
          mismatches++;
        end
        if (out_ch.timed_out !== want.timed_out) begin
          $error("timed_out: expected %0b, got %0b", want.timed_out, out_ch.timed_out);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles where no word moves on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("watchdog: no word moved for %0d cycles", quiet);
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // default registers: on-target from the start, settles on the fifth tick
  task automatic test_reset_defaults();
    int k;
    for (k = 0; k < 6; k++) send_word(16'd0, 1'b0);
    send_word(16'd35999, 1'b1);
    send_word(16'd49, 1'b0);
  endtask

  // widest target, gains and headings; error and speed saturation
  task automatic test_field_extremes();
    load_settings(ErrMin, 65535, 65535, 65535, 4095, 255, 65535);
    write_reg(hpts_pkg::RegNone, 17'h1FFFF);
    send_word(16'hFFFF, 1'b1);
    send_word(16'd0, 1'b0);
    send_word(16'h8000, 1'b0);
    load_settings(ErrMax, 65535, 65535, 65535, 4095, 255, 65535);
    send_word(16'd0, 1'b1);
    send_word(16'hFFFF, 1'b0);
  endtask

  // zero settle count, zero timeout, zero tolerance, restart of a finished turn
  task automatic test_zero_limits();
    int k;
    load_settings(0, 154, 0, 512, 50, 0, 300);
    send_word(16'd35999, 1'b1);
    send_word(16'd0, 1'b0);
    load_settings(0, 154, 0, 512, 50, 5, 0);
    send_word(16'd100, 1'b1);
    send_word(16'd0, 1'b0);
    load_settings(1000, 154, 0, 512, 0, 5, 3);
    for (k = 0; k < 4; k++) send_word(16'd1000, k == 0);
    send_word(16'd1000, 1'b1);
  endtask

  // on-target run climbs all the way to its top value
  task automatic test_run_counter_full();
    int k;
    load_settings(18000, 154, 2, 512, 4095, 255, 65535);
    send_word(16'd18000, 1'b1);
    for (k = 0; k < 260; k++)
      send_word(clip_heading(18000 + int'($urandom_range(0, 400)) - 200), 1'b0);
  endtask

  // integral driven hard at full error both ways, words flowing without gaps
  task automatic test_integral_ramp();
    int k;
    load_settings(ErrMax, 0, 40, 0, 0, 255, 65535);
    steady <= 1'b1;
    send_word(16'd0, 1'b1);
    for (k = 0; k < RampTicks; k++) send_word(16'd0, 1'b0);
    load_settings(ErrMin, 0, 40, 0, 0, 255, 65535);
    send_word(16'hFFFF, 1'b1);
    for (k = 0; k < RampTicks; k++) send_word(16'hFFFF, 1'b0);
    steady <= 1'b0;
  endtask

  // output held off long enough to fill the block, then a full pause
  task automatic test_backpressure();
    int k;
    load_settings(9000, 154, 4, 512, 30, 6, 65535);
    hold_req <= hold_req + 1;
    steady   <= 1'b1;
    send_word(16'd12000, 1'b1);
    for (k = 0; k < 40; k++)
      send_word(clip_heading(9000 + (40 - k) * 60 + int'($urandom_range(0, 20))), 1'b0);
    steady <= 1'b0;
    wait_idle();
  endtask

  // random register set, with corners now and then
  task automatic randomize_settings();
    int tgt, gp, gi, gd, tol, cnt, tmo;
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0: tgt = ErrMin;
        1: tgt = -36000;
        2: tgt = 36000;
        default: tgt = ErrMax;
      endcase
      gp  = $urandom_range(0, 1) ? 65535 : 0;
      gi  = $urandom_range(0, 1) ? 65535 : 0;
      gd  = $urandom_range(0, 1) ? 65535 : 0;
      tol = $urandom_range(0, 1) ? 4095 : 0;
      cnt = $urandom_range(0, 1) ? 255 : 1;
      tmo = $urandom_range(0, 1) ? 65535 : 1;
    end else begin
      tgt = int'($urandom_range(0, 72000)) - 36000;
      gp  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 2048);
      gi  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 128);
      gd  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 2048);
      tol = $urandom_range(0, 7) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 400);
      cnt = $urandom_range(1, 8);
      tmo = $urandom_range(4, 48);
    end
    load_settings(tgt, gp, gi, gd, tol, cnt, tmo);
  endtask

  // turns that close in on the target, mixed with noise words
  task automatic test_random_turns();
    int start, len, off, aim, k, ep;
    start = ticks_sent;
    ep = 0;
    while (ticks_sent - start < RandomTicks) begin
      steady <= (ep % 7 == 3);
      if ($urandom_range(0, 1)) randomize_settings();
      aim = int'($signed(ctl.target_angle));
      len = $urandom_range(2, 30);
      if ($urandom_range(0, 99) < 85) begin
        off = int'($urandom_range(0, 6000)) - 3000;
        for (k = 0; k < len; k++) begin
          send_word(clip_heading(aim + off), k == 0);
          off = off * int'($urandom_range(30, 90)) / 100 + int'($urandom_range(0, 20)) - 10;
        end
      end else begin
        for (k = 0; k < len; k++)
          send_word(HeadingW'($urandom_range(0, 65535)), $urandom_range(0, 9) == 0);
      end
      ep++;
    end
    steady <= 1'b0;
  endtask

  initial begin
    ctl = hpts_pkg::CfgReset;
    clear_loop();
    in_ch.valid          <= 1'b0;
    in_ch.heading_sample <= '0;
    in_ch.restart        <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= hpts_pkg::RegNone;
    cfg_ch.data          <= '0;
    rst_n                <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_zero_limits();
    test_run_counter_full();
    test_backpressure();
    test_random_turns();
    test_integral_ramp();
    wait_idle();

    $display("checked %0d drive words from %0d heading ticks, %0d register writes",
             words_checked, ticks_sent, cfg_writes);
    $display("turns finished: %0d settled, %0d timed out; %0d mismatches",
             n_settled, n_timeouts, mismatches);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
